FILE: rtl/utf8ld_pkg.sv
// shared types and constants of the lenient utf-8 decoder
// no dependencies; used by utf8ld_decode and utf8_lenient_decoder
`default_nettype none

package utf8ld_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 22;
    localparam int unsigned VALUE_W = 21;
    localparam int unsigned M_DATA_W = 24;   // code point padded to whole bytes

    localparam logic signed [CP_W-1:0] INVALID_CP = '1;

    // byte class masks and patterns
    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT    = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT   = 8'hF0;
    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;

    // open sequence state
    typedef struct packed {
        logic [1:0]         needed;   // continuation bytes owed in total by the lead, 0 = idle
        logic [1:0]         seen;     // continuation bytes taken so far
        logic [VALUE_W-1:0] partial;  // code point bits gathered so far
    } dec_state_t;

    // results produced by one byte: invalid markers first, then optional tail
    typedef struct packed {
        logic [1:0]             inv_cnt;
        logic                   tail_valid;
        logic signed [CP_W-1:0] tail_cp;
    } dec_item_t;

endpackage

`default_nettype wire

FILE: rtl/utf8_lenient_decoder.sv
// top level of the lenient streaming utf-8 decoder
// depends on utf8ld_pkg and utf8ld_decode
`default_nettype none

// Lenient UTF-8 decoder. One text byte per request enters on the s_ side; decoded
// code points (up to 21 bits, no overlong or surrogate checks) leave on the m_ side,
// with -1 (all ones) marking an invalid byte. A byte gives zero to four results:
// a broken sequence yields one invalid result per byte already taken, then the
// breaking byte is decoded afresh; a zero byte ends the string and gives nothing
// itself. m_tlast marks the final result caused by each input byte. Rate: one
// byte per cycle while each byte gives at most one result and m_tready holds; a byte
// giving several results holds the single output register for each in turn, and the
// input stalls until the last of them is moving out. The decode step sits between
// the sequence state and a pending-result register, which drains one result per
// cycle, while the output slot is free, into the output register.

module utf8_lenient_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input byte stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [utf8ld_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    // decoded code points
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [utf8ld_pkg::M_DATA_W-1:0]        m_tdata,   // [21:0] code_point, [23:22] zero
    output logic                                   m_tlast    // last_of_run
);

    // sequence state, advanced on every accepted byte
    utf8ld_pkg::dec_state_t state_reg, state_next;
    utf8ld_pkg::dec_item_t  dec_item;

    // pending results of the last accepted byte not yet moved to the output
    logic [2:0]                          pend_rem_reg, pend_rem_next;
    logic                                pend_tail_valid_reg;
    logic signed [utf8ld_pkg::CP_W-1:0]  pend_tail_cp_reg;

    // output register
    logic                                out_valid_reg;
    logic signed [utf8ld_pkg::CP_W-1:0]  out_cp_reg;
    logic                                out_last_reg;

    logic s_accept;
    logic out_free;
    logic move;

    utf8ld_decode u_decode (
        .in_byte    (s_tdata),
        .state_cur  (state_reg),
        .state_next (state_next),
        .item       (dec_item)
    );

    // output slot opens when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign move     = (pend_rem_reg != 3'd0) && out_free;

    // take a new byte once the pending register is empty or draining its last result
    assign s_tready = (pend_rem_reg == 3'd0) || ((pend_rem_reg == 3'd1) && out_free);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        pend_rem_next = pend_rem_reg;
        if (s_accept) begin
            pend_rem_next = {1'b0, dec_item.inv_cnt} + {2'd0, dec_item.tail_valid};
        end else if (move) begin
            pend_rem_next = pend_rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            pend_rem_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            pend_rem_reg <= pend_rem_next;
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_tail_valid_reg <= dec_item.tail_valid;
            pend_tail_cp_reg    <= dec_item.tail_cp;
        end
        if (move) begin
            // invalid markers go first, the tail result (if any) is last
            if (pend_rem_reg == 3'd1 && pend_tail_valid_reg) begin
                out_cp_reg <= pend_tail_cp_reg;
            end else begin
                out_cp_reg <= utf8ld_pkg::INVALID_CP;
            end
            out_last_reg <= (pend_rem_reg == 3'd1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_cp_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/utf8ld_decode.sv
// one-byte step of the lenient utf-8 decoder, purely combinational
// depends on utf8ld_pkg
`default_nettype none

module utf8ld_decode (
    input  wire logic [utf8ld_pkg::BYTE_W-1:0] in_byte,
    input  wire utf8ld_pkg::dec_state_t        state_cur,
    output utf8ld_pkg::dec_state_t             state_next,
    output utf8ld_pkg::dec_item_t              item
);

    logic                              is_cont;
    logic                              fresh;
    logic [1:0]                        seen_inc;
    logic [utf8ld_pkg::VALUE_W-1:0]    partial_ext;

    assign is_cont     = (in_byte & utf8ld_pkg::CONT_MASK) == utf8ld_pkg::CONT_PAT;
    assign seen_inc    = state_cur.seen + 2'd1;
    assign partial_ext = {state_cur.partial[utf8ld_pkg::VALUE_W-7:0],
                          in_byte[5:0]};

    always_comb begin
        state_next      = state_cur;
        item.inv_cnt    = 2'd0;
        item.tail_valid = 1'b0;
        item.tail_cp    = utf8ld_pkg::INVALID_CP;
        fresh           = 1'b1;

        if (state_cur.needed != 2'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (seen_inc >= state_cur.needed) begin
                    item.tail_valid = 1'b1;
                    item.tail_cp    = {1'b0, partial_ext};
                    state_next      = '0;
                end else begin
                    state_next.seen    = seen_inc;
                    state_next.partial = partial_ext;
                end
            end else begin
                // broken sequence: one marker for the lead and each taken byte
                item.inv_cnt = seen_inc;
                state_next   = '0;
            end
        end

        if (fresh && in_byte != '0) begin
            if (in_byte < utf8ld_pkg::ASCII_LIMIT) begin
                item.tail_valid = 1'b1;
                item.tail_cp    = {14'd0, in_byte};
            end else if ((in_byte & utf8ld_pkg::LEAD2_MASK) == utf8ld_pkg::LEAD2_PAT) begin
                state_next.needed  = 2'd1;
                state_next.partial = {16'd0, in_byte[4:0]};
            end else if ((in_byte & utf8ld_pkg::LEAD3_MASK) == utf8ld_pkg::LEAD3_PAT) begin
                state_next.needed  = 2'd2;
                state_next.partial = {17'd0, in_byte[3:0]};
            end else if ((in_byte & utf8ld_pkg::LEAD4_MASK) == utf8ld_pkg::LEAD4_PAT) begin
                state_next.needed  = 2'd3;
                state_next.partial = {18'd0, in_byte[2:0]};
            end else begin
                item.tail_valid = 1'b1;
                item.tail_cp    = utf8ld_pkg::INVALID_CP;
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/utf8_lenient_decoder_tb.sv
// self-checking testbench for utf8_lenient_decoder: byte stream in, code points out
// needs utf8ld_pkg and the decoder rtl; predicts results with its own decoder model
`timescale 1ns / 1ps

module utf8_lenient_decoder_tb;

    import utf8ld_pkg::*;

    // one decoded result as the block should present it
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
    } cp_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata  = '0;   // [7:0] in_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;         // [21:0] code_point, [23:22] zero
    logic                 m_tlast;         // last_of_run

    utf8_lenient_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor copy of the open sequence
    logic [1:0]         seq_needed  = '0;
    logic [1:0]         seq_seen    = '0;
    logic [VALUE_W-1:0] seq_partial = '0;

    cp_result_t pending_cps[$];    // code points still owed by the block
    int         fail_count  = 0;
    int         bytes_sent  = 0;
    int         burst_left  = 0;
    bit         tx_gaps_on  = 0;   // sender idles between bursts
    bit         rx_stall_on = 0;   // receiver drops tready
    int unsigned rx_cycle   = 0;

    // decode one accepted byte and queue the results it should cause
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        cp_result_t  res[4];
        int          n_out;
        bit          fresh;
        int          k;
        n_out = 0;
        fresh = 1;
        if (seq_needed != 0) begin
            if (b != 0 && (b & CONT_MASK) == CONT_PAT) begin
                // continuation: shift in six payload bits
                seq_partial = {seq_partial[VALUE_W-7:0], b[5:0]};
                seq_seen    = seq_seen + 2'd1;
                if (seq_seen >= seq_needed) begin
                    res[n_out].cp = {1'b0, seq_partial};
                    n_out++;
                    seq_needed  = '0;
                    seq_seen    = '0;
                    seq_partial = '0;
                end
                fresh = 0;
            end else begin
                // broken sequence: one invalid for the lead and each continuation taken
                for (k = 0; k <= seq_seen && k < 3; k++) begin
                    res[n_out].cp = INVALID_CP;
                    n_out++;
                end
                seq_needed  = '0;
                seq_seen    = '0;
                seq_partial = '0;
            end
        end
        if (fresh && b != 0) begin
            if (b < ASCII_LIMIT) begin
                res[n_out].cp = {14'd0, b};
                n_out++;
            end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                seq_needed  = 2'd1;
                seq_partial = {16'd0, b[4:0]};
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                seq_needed  = 2'd2;
                seq_partial = {17'd0, b[3:0]};
            end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                seq_needed  = 2'd3;
                seq_partial = {18'd0, b[2:0]};
            end else begin
                // stray continuation or f8-ff as a lead
                res[n_out].cp = INVALID_CP;
                n_out++;
            end
        end
        for (k = 0; k < n_out; k++) begin
            res[k].last = (k == n_out - 1);
            pending_cps.push_back(res[k]);
        end
    endfunction

    // result checker; tready pattern mixes a slow cycle pattern with random drops
    always @(posedge aclk) begin
        cp_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (m_tvalid && m_tready) begin
                if (pending_cps.size() == 0) begin
                    $error("unexpected result: code_point %h last_of_run %b",
                           m_tdata[CP_W-1:0], m_tlast);
                    fail_count++;
                end else begin
                    want = pending_cps.pop_front();
                    if (m_tdata[CP_W-1:0] !== want.cp) begin
                        $error("code_point mismatch: expected %h, actual %h",
                               want.cp, m_tdata[CP_W-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run mismatch: expected %b, actual %b",
                               want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (rx_stall_on)
                m_tready <= !(($urandom_range(0, 3) == 0) ||
                              (rx_cycle[5:4] == 2'b11 && rx_cycle[1:0] != 2'b00));
            else
                m_tready <= 1'b1;
        end
    end

    // hold the sender quiet for some cycles; lowers tvalid once
    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // offer one byte, wait for the request to be taken, then maybe pause
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b);
        bytes_sent++;
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                idle_sender($urandom_range(1, 6));
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop sending until every queued code point has come out
    task automatic wait_for_results();
        idle_sender(1);
        while (pending_cps.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_lead(input int k);
        logic [7:0] r;
        r = 8'($urandom);
        case (k)
            1: begin
                return {3'b110, r[4:0]};
            end
            2: begin
                return {4'b1110, r[3:0]};
            end
            default: begin
                return {5'b11110, r[2:0]};
            end
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_cont();
        logic [7:0] r;
        r = 8'($urandom);
        return {2'b10, r[5:0]};
    endfunction

    // ascii extremes and the end-of-string byte with nothing open
    task automatic test_ascii_and_end_marker();
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h7F);
    endtask

    // bytes that cannot start a sequence
    task automatic test_stray_bytes();
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hF8);
        send_byte(8'hFF);
    endtask

    // smallest and largest payloads of the two byte form, top of three and four byte forms
    task automatic test_complete_sequences();
        send_byte(8'hC0); send_byte(8'h80);
        send_byte(8'hDF); send_byte(8'hBF);
        send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
    endtask

    // sequences cut short by ascii, by a stray lead (four results), by end of string and by a new lead
    task automatic test_broken_sequences();
        send_byte(8'hE2); send_byte(8'h82); send_byte(8'h41);
        send_byte(8'hF0); send_byte(8'h80); send_byte(8'h80); send_byte(8'hF8);
        send_byte(8'hC3); send_byte(8'h00);
        send_byte(8'hC3); send_byte(8'hC3); send_byte(8'hA9);
    endtask

    // mostly well-formed text with random content, some noise and cut sequences
    task automatic send_random_chunk();
        int         pick;
        int         k;
        int         j;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_byte(8'($urandom_range(1, 127)));
        end else if (pick < 75) begin
            k = (pick < 45) ? 1 : (pick < 60) ? 2 : 3;
            send_byte(rand_lead(k));
            repeat (k) send_byte(rand_cont());
        end else if (pick < 80) begin
            send_byte(8'h00);
        end else if (pick < 85) begin
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 90) begin
            send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
            // lead, fewer continuations than owed, then any non-continuation byte
            k = $urandom_range(1, 3);
            send_byte(rand_lead(k));
            j = $urandom_range(0, k - 1);
            repeat (j) send_byte(rand_cont());
            b = 8'($urandom_range(0, 255));
            if ((b & CONT_MASK) == CONT_PAT)
                b = b ^ 8'h40;
            send_byte(b);
        end
    endtask

    // four phases: no idling, sender gaps, receiver stalls, then both
    task automatic test_random_text(input int count);
        int phase;
        int target;
        for (phase = 0; phase < 4; phase++) begin
            tx_gaps_on  = phase[0];
            rx_stall_on = phase[1];
            target = bytes_sent + count / 4;
            while (bytes_sent < target) send_random_chunk();
            wait_for_results();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ascii_and_end_marker();
        tx_gaps_on = 1;
        test_stray_bytes();
        rx_stall_on = 1;
        test_complete_sequences();
        test_broken_sequences();
        wait_for_results();
        test_random_text(430);

        // let any stray result surface before the verdict
        rx_stall_on = 0;
        wait_for_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
